// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int ByteW = 8;
  localparam int LenW  = 24;   // width of the length limit register
  localparam int CntW  = 25;   // decoded length counter

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DATA   = 2'd0;
  localparam kind_t KIND_CLOSED = 2'd1;
  localparam kind_t KIND_ERROR  = 2'd2;

  typedef logic [2:0] err_t;
  localparam err_t ERR_NONE          = 3'd0;
  localparam err_t ERR_NO_QUOTE      = 3'd1;
  localparam err_t ERR_EARLY_END     = 3'd2;
  localparam err_t ERR_BAD_ESCAPE    = 3'd3;
  localparam err_t ERR_BAD_HEX       = 3'd4;
  localparam err_t ERR_BAD_SURROGATE = 3'd5;
  localparam err_t ERR_TOO_LONG      = 3'd6;

  // One queued request: up to four results for one input byte.
  typedef struct packed {
    logic [1:0]            last_idx;  // number of results minus one
    logic [3:0][ByteW-1:0] bytes;
    kind_t                 kind;
    err_t                  code;
  } job_t;

endpackage

// File: rtl/json_string_unescape_utf8_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// JSON string literal unescaper with UTF-8 output and a length limit.
//
//   channel   dir  content
//   s_axis    in   tdata = in_byte, tuser = end_of_text
//   m_axis    out  tdata = out_byte, tuser = {error_code, kind}, tlast = last
//   apb       in   reg 0 at 0x0: max_string_len (24 bit)
//
// One input byte is taken per cycle while the request queue has room.
// An input byte yields zero to four results; the serialiser sends one
// result per cycle while m_axis_tready is high, a code point byte by byte.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled output fills the queue, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit
  import jsu_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_axis_tuser,   // [0] end_of_text
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [4:0]  m_axis_tuser,   // [1:0] kind, [4:2] error_code
  output logic        m_axis_tlast
);

  logic [LenW-1:0] max_len_q;
  logic            accept;
  logic            push, pop, q_empty, q_full;
  job_t            push_job, head_job;
  kind_t           kind;
  err_t            code;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-LenW){1'b0}}, max_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= 24'h100000;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      max_len_q <= pwdata[LenW-1:0];
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && !q_full;

  jsu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (s_axis_tdata),
    .end_of_text_i (s_axis_tuser[0]),
    .max_len_i     (max_len_q),
    .push_o        (push),
    .job_o         (push_job)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .kind_o       (kind),
    .code_o       (code),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tuser = {code, kind};

endmodule

// File: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser front end: walks the string state machine one accepted byte per
// cycle, encodes code points to UTF-8, checks the length, issues result jobs.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             end_of_text_i,
  input  logic [LenW-1:0]  max_len_i,
  output logic             push_o,
  output job_t             job_o
);

  localparam logic [2:0] M_AWAIT     = 3'd0;
  localparam logic [2:0] M_IN_STRING = 3'd1;
  localparam logic [2:0] M_ESCAPE    = 3'd2;
  localparam logic [2:0] M_HEX_FIRST = 3'd3;
  localparam logic [2:0] M_WANT_BSL  = 3'd4;
  localparam logic [2:0] M_WANT_U    = 3'd5;
  localparam logic [2:0] M_HEX_LOW   = 3'd6;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;

  logic [2:0]      mode_q, mode_d;
  logic [15:0]     accum_q, accum_d;
  logic [1:0]      digits_q, digits_d;
  logic [9:0]      hsur_q, hsur_d;
  logic [CntW-1:0] len_q, len_d;

  logic            hex_ok;
  logic [3:0]      hex_v;
  logic [15:0]     accum_new;
  logic [20:0]     cp;
  logic [1:0]      enc_last;
  logic [3:0][7:0] enc_bytes;
  logic            esc_ok;
  logic [7:0]      esc_byte;
  logic [1:0]      em_last;
  logic [3:0][7:0] em_bytes;
  logic [CntW:0]   len_sum;
  logic            too_long;

  // hex digit decode
  always_comb begin
    hex_ok = 1'b0;
    hex_v  = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_ok = 1'b1;
      hex_v  = in_byte_i[3:0];
    end else if ((in_byte_i >= 8'h61 && in_byte_i <= 8'h66) ||
                 (in_byte_i >= 8'h41 && in_byte_i <= 8'h46)) begin
      hex_ok = 1'b1;
      hex_v  = in_byte_i[3:0] + 4'd9;
    end
  end

  assign accum_new = {accum_q[11:0], hex_v};
  // low surrogate minus DC00 is its low ten bits
  assign cp = (mode_q == M_HEX_LOW) ? (21'h10000 + {1'b0, hsur_q, accum_new[9:0]})
                                    : {5'd0, accum_new};

  // UTF-8 encoder
  always_comb begin
    enc_bytes = '0;
    if (cp < 21'h80) begin
      enc_last     = 2'd0;
      enc_bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      enc_last     = 2'd1;
      enc_bytes[0] = {3'b110, cp[10:6]};
      enc_bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      enc_last     = 2'd2;
      enc_bytes[0] = {4'b1110, cp[15:12]};
      enc_bytes[1] = {2'b10, cp[11:6]};
      enc_bytes[2] = {2'b10, cp[5:0]};
    end else begin
      enc_last     = 2'd3;
      enc_bytes[0] = {5'b11110, cp[20:18]};
      enc_bytes[1] = {2'b10, cp[17:12]};
      enc_bytes[2] = {2'b10, cp[11:6]};
      enc_bytes[3] = {2'b10, cp[5:0]};
    end
  end

  always_comb begin
    esc_ok = 1'b1;
    case (in_byte_i)
      8'h22:   esc_byte = 8'h22;
      8'h5C:   esc_byte = 8'h5C;
      8'h2F:   esc_byte = 8'h2F;
      8'h6E:   esc_byte = 8'h0A;
      8'h74:   esc_byte = 8'h09;
      8'h72:   esc_byte = 8'h0D;
      8'h62:   esc_byte = 8'h08;
      8'h66:   esc_byte = 8'h0C;
      default: begin
        esc_ok   = 1'b0;
        esc_byte = 8'h00;
      end
    endcase
  end

  // bytes that a data emission in this cycle would carry
  always_comb begin
    em_bytes = '0;
    em_last  = 2'd0;
    case (mode_q)
      M_IN_STRING: em_bytes[0] = in_byte_i;
      M_ESCAPE:    em_bytes[0] = esc_byte;
      default: begin
        em_bytes = enc_bytes;
        em_last  = enc_last;
      end
    endcase
  end

  assign len_sum  = {1'b0, len_q} + {{(CntW-1){1'b0}}, em_last} + {{CntW{1'b0}}, 1'b1};
  assign too_long = len_sum > {2'b00, max_len_i};

  always_comb begin
    mode_d   = mode_q;
    accum_d  = accum_q;
    digits_d = digits_q;
    hsur_d   = hsur_q;
    len_d    = len_q;
    push_o   = 1'b0;
    job_o    = '0;

    if (end_of_text_i) begin
      push_o     = 1'b1;
      job_o.kind = KIND_ERROR;
      job_o.code = ERR_EARLY_END;
      mode_d     = M_AWAIT;
    end else begin
      case (mode_q)
        M_IN_STRING: begin
          if (in_byte_i == CH_QUOTE) begin
            push_o     = 1'b1;
            job_o.kind = KIND_CLOSED;
            mode_d     = M_AWAIT;
          end else if (in_byte_i == CH_BSL) begin
            mode_d = M_ESCAPE;
          end else begin
            push_o = 1'b1;
          end
        end
        M_ESCAPE: begin
          if (in_byte_i == CH_U) begin
            accum_d  = '0;
            digits_d = '0;
            mode_d   = M_HEX_FIRST;
          end else if (esc_ok) begin
            push_o = 1'b1;
          end else begin
            push_o     = 1'b1;
            job_o.kind = KIND_ERROR;
            job_o.code = ERR_BAD_ESCAPE;
            mode_d     = M_AWAIT;
          end
        end
        M_HEX_FIRST, M_HEX_LOW: begin
          if (!hex_ok) begin
            push_o     = 1'b1;
            job_o.kind = KIND_ERROR;
            job_o.code = ERR_BAD_HEX;
            mode_d     = M_AWAIT;
          end else begin
            accum_d = accum_new;
            if (digits_q != 2'd3) begin
              digits_d = digits_q + 2'd1;
            end else begin
              digits_d = '0;
              if (mode_q == M_HEX_FIRST) begin
                if (accum_new >= 16'hD800 && accum_new <= 16'hDBFF) begin
                  hsur_d = accum_new[9:0];
                  mode_d = M_WANT_BSL;
                end else begin
                  push_o = 1'b1;
                end
              end else if (accum_new >= 16'hDC00 && accum_new <= 16'hDFFF) begin
                push_o = 1'b1;
              end else begin
                push_o     = 1'b1;
                job_o.kind = KIND_ERROR;
                job_o.code = ERR_BAD_SURROGATE;
                mode_d     = M_AWAIT;
              end
            end
          end
        end
        M_WANT_BSL: begin
          if (in_byte_i == CH_BSL) begin
            mode_d = M_WANT_U;
          end else begin
            push_o     = 1'b1;
            job_o.kind = KIND_ERROR;
            job_o.code = ERR_BAD_SURROGATE;
            mode_d     = M_AWAIT;
          end
        end
        M_WANT_U: begin
          if (in_byte_i == CH_U) begin
            accum_d  = '0;
            digits_d = '0;
            mode_d   = M_HEX_LOW;
          end else begin
            push_o     = 1'b1;
            job_o.kind = KIND_ERROR;
            job_o.code = ERR_BAD_SURROGATE;
            mode_d     = M_AWAIT;
          end
        end
        default: begin
          if (in_byte_i == CH_QUOTE) begin
            len_d  = '0;
            mode_d = M_IN_STRING;
          end else begin
            push_o     = 1'b1;
            job_o.kind = KIND_ERROR;
            job_o.code = ERR_NO_QUOTE;
            mode_d     = M_AWAIT;
          end
        end
      endcase

      // a data request goes through the length check
      if (push_o && job_o.kind == KIND_DATA) begin
        if (too_long) begin
          job_o.kind = KIND_ERROR;
          job_o.code = ERR_TOO_LONG;
          mode_d     = M_AWAIT;
        end else begin
          job_o.bytes    = em_bytes;
          job_o.last_idx = em_last;
          len_d          = len_sum[CntW-1:0];
          mode_d         = M_IN_STRING;
        end
      end
    end

    if (!accept_i) begin
      push_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_AWAIT;
      accum_q  <= '0;
      digits_q <= '0;
      hsur_q   <= '0;
      len_q    <= '0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      accum_q  <= accum_d;
      digits_q <= digits_d;
      hsur_q   <= hsur_d;
      len_q    <= len_d;
    end
  end

endmodule

// File: rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small request queue between the parser and the output serialiser.
// ----------------------------------------------------------------------------
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o,
  output logic full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FillW = $clog2(Depth + 1);

  job_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [FillW-1:0] fill_q, fill_d;

  assign empty_o = (fill_q == '0);
  assign full_o  = (fill_q == FillW'(Depth));
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

endmodule

// File: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Output serialiser: spreads each queued request over one result per cycle
// while the output is ready, into a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  job_t             head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output kind_t            kind_o,
  output err_t             code_o,
  output logic             last_o
);

  logic             valid_q, valid_d;
  logic [1:0]       idx_q, idx_d;
  logic [ByteW-1:0] byte_q;
  kind_t            kind_q;
  err_t             code_q;
  logic             last_q;
  logic             load;
  logic             is_last;

  assign load    = !valid_q || out_ready_i;
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && head_valid_i && is_last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        idx_d = is_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      byte_q <= head_i.bytes[idx_q];
      kind_q <= head_i.kind;
      code_q <= head_i.code;
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign kind_o      = kind_q;
  assign code_o      = code_q;
  assign last_o      = last_q;

endmodule
